@@ src/timed_light_door_controller_core_macros.svh @@
// Assertion macros shared by the door controller RTL
`ifndef TIMED_LIGHT_DOOR_CONTROLLER_CORE_MACROS_SVH
`define TIMED_LIGHT_DOOR_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define TLDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define TLDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/tldc_pkg.sv @@
// Types and constants of the timed light door controller
`timescale 1ns / 1ps

package tldc_pkg;

	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned LIGHT_W = 17;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned SERVO_W = 8;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 17;

	localparam logic [SERVO_W-1:0] SERVO_OPEN  = 8'd60;
	localparam logic [SERVO_W-1:0] SERVO_CLOSE = 8'd120;
	localparam logic [TICK_W-1:0]  TICK_MAX    = 16'hFFFF;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_HOUR_OPEN       = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOUR_CLOSE      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ABS_HOUR_CLOSE  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ABS_HOUR_OPEN   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_CLOSE     = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_OPEN      = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MOVING      = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_PERIOD    = 4'd7;

	// register reset values
	localparam logic [HOUR_W-1:0]  RST_HOUR_OPEN      = 5'd4;
	localparam logic [HOUR_W-1:0]  RST_HOUR_CLOSE     = 5'd19;
	localparam logic [HOUR_W-1:0]  RST_ABS_HOUR_CLOSE = 5'd23;
	localparam logic [HOUR_W-1:0]  RST_ABS_HOUR_OPEN  = 5'd8;
	localparam logic [LIGHT_W-1:0] RST_LIGHT_CLOSE    = 17'd20;
	localparam logic [LIGHT_W-1:0] RST_LIGHT_OPEN     = 17'd200;
	localparam logic [TICK_W-1:0]  RST_MAX_MOVING     = 16'd18000;
	localparam logic [TICK_W-1:0]  RST_CHECK_PERIOD   = 16'd1000;

	typedef struct packed {
		logic [HOUR_W-1:0]  hour;
		logic [LIGHT_W-1:0] light_half_lux;
		logic               open_limit_rise;
		logic               close_limit_rise;
		logic               open_limit_low;
		logic               close_limit_low;
		logic               open_button;
		logic               close_button;
	} in_item_t;

	typedef struct packed {
		logic               motor_on;
		logic [SERVO_W-1:0] servo_command;
		logic               is_opening;
		logic               is_closing;
		logic               is_opened;
		logic               is_closed;
		logic               safety_stopped;
	} out_item_t;

	typedef struct packed {
		logic [HOUR_W-1:0]  hour_open;
		logic [HOUR_W-1:0]  hour_close;
		logic [HOUR_W-1:0]  absolute_hour_close;
		logic [HOUR_W-1:0]  absolute_hour_open;
		logic [LIGHT_W-1:0] light_close;
		logic [LIGHT_W-1:0] light_open;
		logic [TICK_W-1:0]  max_moving_ticks;
		logic [TICK_W-1:0]  check_period_ticks;
	} cfg_regs_t;

	typedef struct packed {
		logic               opening;
		logic               closing;
		logic               opened;
		logic               closed;
		logic               safety;
		logic               motor;
		logic [SERVO_W-1:0] servo;
		logic [TICK_W-1:0]  check_ticks;
		logic [TICK_W-1:0]  moving_ticks;
		logic               started;
	} door_state_t;

endpackage

@@ src/timed_light_door_controller_core.sv @@
// Timed light door controller: top level with input, state and result registers
// A request is held in the input stage, then its result is written to the result register and shown on out_valid.
// Throughput: one request per cycle; the door state register closes the per-tick loop.
// A full result register that is not taken stalls the input stage, and in_ready drops.
// Reset (arst_n low, asynchronous): door state cleared, registers at defaults, no valid data.
`timescale 1ns / 1ps
`include "timed_light_door_controller_core_macros.svh"

module timed_light_door_controller_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  tldc_pkg::in_item_t                     in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output tldc_pkg::out_item_t                    out_data,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [tldc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tldc_pkg::CFG_DATA_W-1:0]        cfg_data
);

	tldc_pkg::cfg_regs_t   cfg_q;
	tldc_pkg::door_state_t state_q;
	tldc_pkg::door_state_t state_nxt;
	tldc_pkg::in_item_t    item_s1;
	logic                  valid_s1;
	tldc_pkg::out_item_t   result_q;
	logic                  result_valid_q;
	logic                  advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!result_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hour_open          <= tldc_pkg::RST_HOUR_OPEN;
			cfg_q.hour_close         <= tldc_pkg::RST_HOUR_CLOSE;
			cfg_q.absolute_hour_close <= tldc_pkg::RST_ABS_HOUR_CLOSE;
			cfg_q.absolute_hour_open <= tldc_pkg::RST_ABS_HOUR_OPEN;
			cfg_q.light_close        <= tldc_pkg::RST_LIGHT_CLOSE;
			cfg_q.light_open         <= tldc_pkg::RST_LIGHT_OPEN;
			cfg_q.max_moving_ticks   <= tldc_pkg::RST_MAX_MOVING;
			cfg_q.check_period_ticks <= tldc_pkg::RST_CHECK_PERIOD;
		end else if (cfg_valid) begin
			case (cfg_index)
				tldc_pkg::REG_HOUR_OPEN:
					cfg_q.hour_open <= cfg_data[tldc_pkg::HOUR_W-1:0];
				tldc_pkg::REG_HOUR_CLOSE:
					cfg_q.hour_close <= cfg_data[tldc_pkg::HOUR_W-1:0];
				tldc_pkg::REG_ABS_HOUR_CLOSE:
					cfg_q.absolute_hour_close <= cfg_data[tldc_pkg::HOUR_W-1:0];
				tldc_pkg::REG_ABS_HOUR_OPEN:
					cfg_q.absolute_hour_open <= cfg_data[tldc_pkg::HOUR_W-1:0];
				tldc_pkg::REG_LIGHT_CLOSE:
					cfg_q.light_close <= cfg_data[tldc_pkg::LIGHT_W-1:0];
				tldc_pkg::REG_LIGHT_OPEN:
					cfg_q.light_open <= cfg_data[tldc_pkg::LIGHT_W-1:0];
				tldc_pkg::REG_MAX_MOVING:
					cfg_q.max_moving_ticks <= cfg_data[tldc_pkg::TICK_W-1:0];
				tldc_pkg::REG_CHECK_PERIOD:
					cfg_q.check_period_ticks <= cfg_data[tldc_pkg::TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	tldc_step u_step (
		.item (item_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q        <= state_nxt;
				result_valid_q <= 1'b1;
			end else if (out_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.motor_on       <= state_nxt.motor;
			result_q.servo_command  <= state_nxt.servo;
			result_q.is_opening     <= state_nxt.opening;
			result_q.is_closing     <= state_nxt.closing;
			result_q.is_opened      <= state_nxt.opened;
			result_q.is_closed      <= state_nxt.closed;
			result_q.safety_stopped <= state_nxt.safety;
		end
	end

	assign out_valid = result_valid_q;
	assign out_data  = result_q;

	`TLDC_ASSERT_NEXT(a_stall_holds_s1, valid_s1 && !advance, valid_s1,
		"stalled request lost from input stage")
	`TLDC_ASSERT_NEXT(a_advance_fills_out, advance, result_valid_q,
		"advanced request gave no result")
	`TLDC_ASSERT_NOW(a_servo_code, result_valid_q,
		(result_q.servo_command == 8'd0) || (result_q.servo_command == tldc_pkg::SERVO_OPEN) ||
		(result_q.servo_command == tldc_pkg::SERVO_CLOSE), "servo command outside its codes")
	`TLDC_ASSERT_NOW(a_safety_idle, state_q.safety,
		!state_q.opening && !state_q.closing && !state_q.motor,
		"safety stop with door still driven")

endmodule

@@ src/tldc_step.sv @@
// Next-state logic for one tick: limits, periodic rules, timeout, buttons
`timescale 1ns / 1ps

module tldc_step (
	input  tldc_pkg::in_item_t    item,
	input  tldc_pkg::cfg_regs_t   cfg,
	input  tldc_pkg::door_state_t cur,
	output tldc_pkg::door_state_t nxt
);

	function automatic tldc_pkg::door_state_t start_move(
		input tldc_pkg::door_state_t s,
		input logic                  to_open
	);
		tldc_pkg::door_state_t r;
		r = s;
		if (to_open) begin
			r.opening = 1'b1;
			r.servo   = tldc_pkg::SERVO_OPEN;
		end else begin
			r.closing = 1'b1;
			r.servo   = tldc_pkg::SERVO_CLOSE;
		end
		r.motor        = 1'b1;
		r.moving_ticks = '0;
		return r;
	endfunction

	function automatic logic idle_safe(input tldc_pkg::door_state_t s);
		return !s.opening && !s.closing && !s.safety;
	endfunction

	logic night, day, early, late_open;

	// hour rules depend only on the item and registers
	assign night     = (item.hour >= cfg.hour_close) || (item.hour < cfg.hour_open);
	assign day       = (item.hour < cfg.hour_close) && (item.hour >= cfg.hour_open);
	assign early     = (item.hour >= cfg.absolute_hour_close) || (item.hour < cfg.hour_open);
	assign late_open = (item.hour < cfg.hour_close) && (item.hour >= cfg.absolute_hour_open);

	always_comb begin
		tldc_pkg::door_state_t s;
		s = cur;

		// first tick loads the limit levels
		if (!s.started) begin
			s.started = 1'b1;
			if (item.close_limit_low) s.closed = 1'b1;
			if (item.open_limit_low) s.opened = 1'b1;
		end

		if (s.check_ticks != tldc_pkg::TICK_MAX) s.check_ticks = s.check_ticks + 16'd1;
		if (s.moving_ticks != tldc_pkg::TICK_MAX) s.moving_ticks = s.moving_ticks + 16'd1;

		if (item.open_limit_rise && s.opening) begin
			s.opening = 1'b0;
			s.motor   = 1'b0;
			s.opened  = 1'b1;
			s.closed  = 1'b0;
		end
		if (item.close_limit_rise && s.closing) begin
			s.closing = 1'b0;
			s.motor   = 1'b0;
			s.closed  = 1'b1;
			s.opened  = 1'b0;
		end

		if (s.check_ticks > cfg.check_period_ticks) begin
			s.check_ticks = '0;
			if (night && (item.light_half_lux < cfg.light_close) && !s.closed && idle_safe(s))
				s = start_move(s, 1'b0);
			if (day && (item.light_half_lux > cfg.light_open) && !s.opened && idle_safe(s))
				s = start_move(s, 1'b1);
			if (early && !s.closed && idle_safe(s))
				s = start_move(s, 1'b0);
			if (late_open && !s.opened && idle_safe(s))
				s = start_move(s, 1'b1);
		end

		// movement timeout latches the safety stop
		if ((s.opening || s.closing) && (s.moving_ticks > cfg.max_moving_ticks)) begin
			s.motor   = 1'b0;
			s.opening = 1'b0;
			s.closing = 1'b0;
			s.opened  = 1'b0;
			s.closed  = 1'b0;
			s.safety  = 1'b1;
		end

		if (item.open_button && !s.opening && !s.opened) begin
			s = start_move(s, 1'b1);
			s.safety = 1'b0;
		end
		if (item.close_button && !s.closing && !s.closed) begin
			s = start_move(s, 1'b0);
			s.safety = 1'b0;
		end

		nxt = s;
	end

endmodule
